FILE: hdl/lfu_pkg.sv
package lfu_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_KEY_WIDTH   = 32;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_COUNT_WIDTH = 16;

  // Capacity register.
  localparam int              CFG_W     = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // Request kinds carried in the input tuser.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the request and clear the scan results
    logic scan;    // read one entry and step the entry counter
    logic decide;  // latch the outcome of the scan
    logic upd;     // read one age rank for the rank update pass
    logic commit;  // write the target entry, valid bits and occupancy
    logic emit;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;         // entry counter is at the last entry
    logic need_update;  // the request changes the table
    logic out_free;     // result register can take a new word
  } sts_t;

endpackage

FILE: hdl/lfu_cache_table.sv
// Channel   Direction  Signals                    Contents
// config    in         cfg_we, cfg_wdata[4:0]     capacity_in_use
// request   in         s_tvalid/tready/tdata/tuser  key, value, get or put
// result    out        m_tvalid/tready/tdata/tuser  value, evicted key, flags
//
// A request that leaves the table unchanged (get miss, put with zero capacity) makes one
// pass over the entry RAM, which finds the key, the victim and a free entry; any other
// request then makes a second pass, over the rank RAM, that rewrites the ranks.
// Reset (rst, synchronous) empties the table at once through the valid bits and sets
// the capacity register to 16. The result register holds a word for m_tready while the
// next request is accepted; s_tready is high only between requests.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic clk,
  input  logic rst,

  // Capacity register write.
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,

  // Request stream.
  input  logic s_tvalid,
  output logic s_tready,
  // tdata, low bits up: lookup_key, write_value, zero fill
  input  logic [((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // tuser: req_type (0 get, 1 put)
  input  logic [0:0] s_tuser,

  // Result stream.
  output logic m_tvalid,
  input  logic m_tready,
  // tdata, low bits up: read_value, evicted_key, zero fill
  output logic [((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  // tuser, low bit up: hit, evicted
  output logic [1:0] m_tuser
);

  localparam int DATA_W = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  logic                   out_hit;
  logic [VALUE_WIDTH-1:0] out_read;
  logic                   out_evicted;
  logic [KEY_WIDTH-1:0]   out_evicted_key;

  // The controller sequences the scan, decision, rank pass and commit;
  // it only ever sees the datapath through the command and status words.
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the capacity register, valid bits, occupancy, both
  // RAMs, the scan trackers and the result register.
  lfu_dp #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_type    (s_tuser[0]),
    .lookup_key  (s_tdata[KEY_WIDTH-1:0]),
    .write_value (s_tdata[KEY_WIDTH +: VALUE_WIDTH]),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .hit         (out_hit),
    .read_value  (out_read),
    .evicted     (out_evicted),
    .evicted_key (out_evicted_key)
  );

  // Pack the result word; the size cast fills the top with zeros.
  assign m_tdata = DATA_W'({out_evicted_key, out_read});
  assign m_tuser = {out_evicted, out_hit};

endmodule

FILE: hdl/lfu_ram.sv
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lfu_ctrl.sv
module lfu_ctrl import lfu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    SCAN_END,
    DECIDE,
    UPDATE,
    UPD_END,
    COMMIT,
    RESULT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (sts.last) begin
            state <= SCAN_END;
          end
        end
        SCAN_END: state <= DECIDE;
        DECIDE: begin
          state <= sts.need_update ? UPDATE : RESULT;
        end
        UPDATE: begin
          if (sts.last) begin
            state <= UPD_END;
          end
        end
        UPD_END: state <= COMMIT;
        COMMIT:  state <= RESULT;
        RESULT: begin
          if (sts.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    cmd.start  = (state == IDLE) && s_tvalid;
    cmd.scan   = (state == SCAN);
    cmd.decide = (state == DECIDE);
    cmd.upd    = (state == UPDATE);
    cmd.commit = (state == COMMIT);
    cmd.emit   = (state == RESULT) && sts.out_free;
  end

endmodule

FILE: hdl/lfu_dp.sv
module lfu_dp import lfu_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   req_type,
  input  logic [KEY_WIDTH-1:0]   lookup_key,
  input  logic [VALUE_WIDTH-1:0] write_value,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   hit,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic                   evicted,
  output logic [KEY_WIDTH-1:0]   evicted_key
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CAP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam int ROW_W = KEY_WIDTH + VALUE_WIDTH + COUNT_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CAPACITY - 1);
  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CAPACITY);

  // Configuration and table control state.
  logic [CFG_W-1:0]    cap_cfg;
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] valid_next;
  logic [OCC_W-1:0]    occ;

  // Latched request.
  logic                   req_put;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_value;

  // Entry counter and the delayed index of the word coming out of the RAMs.
  logic             cnt_last;
  logic [IDX_W-1:0] cnt;
  logic             eval_en;
  logic [IDX_W-1:0] eval_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;

  // RAM ports.
  logic [ROW_W-1:0]       row_rd;
  logic [ROW_W-1:0]       row_wr;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [IDX_W-1:0]       rank_rd;
  logic [IDX_W-1:0]       rank_new;
  logic                   rank_we;

  // Scan results.
  logic                   match_found;
  logic [IDX_W-1:0]       match_idx;
  logic [VALUE_WIDTH-1:0] match_value;
  logic [COUNT_WIDTH-1:0] match_count;
  logic [IDX_W-1:0]       match_rank;
  logic                   victim_found;
  logic [IDX_W-1:0]       victim_idx;
  logic [KEY_WIDTH-1:0]   victim_key;
  logic [COUNT_WIDTH-1:0] victim_count;
  logic [IDX_W-1:0]       victim_rank;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;

  // Decision, combinational and latched.
  logic [CAP_W-1:0] cap_ext;
  logic [CAP_W-1:0] cap_eff;
  logic [CAP_W-1:0] occ_ext;
  logic             touch_c;
  logic             insert_c;
  logic             evict_c;
  logic [IDX_W-1:0] target_c;
  logic             touch_l;
  logic             insert_l;
  logic             evict_l;
  logic [IDX_W-1:0] target_l;
  logic [IDX_W-1:0] thr_l;
  logic             use_thr_l;

  logic                   ev_valid;
  logic                   better;
  logic                   out_free;
  logic [COUNT_WIDTH-1:0] count_wr;
  logic [VALUE_WIDTH-1:0] value_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg <= CAP_RESET;
    end else if (cfg_we) begin
      cap_cfg <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_put   <= req_type;
      req_key   <= lookup_key;
      req_value <= write_value;
    end
  end

  // The counter wraps to zero after the last entry, so the rank pass
  // starts at entry zero right after the scan.
  assign cnt_last = (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      eval_en <= 1'b0;
      wr_en   <= 1'b0;
    end else begin
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.scan || cmd.upd) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      eval_en <= cmd.scan;
      wr_en   <= cmd.upd;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= cnt;
    wr_idx   <= cnt;
  end

  lfu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CAPACITY)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (target_l),
    .wdata (row_wr),
    .re    (cmd.scan),
    .raddr (cnt),
    .rdata (row_rd)
  );

  lfu_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (wr_idx),
    .wdata (rank_new),
    .re    (cmd.scan || cmd.upd),
    .raddr (cnt),
    .rdata (rank_rd)
  );

  assign rd_key   = row_rd[KEY_WIDTH-1:0];
  assign rd_value = row_rd[KEY_WIDTH +: VALUE_WIDTH];
  assign rd_count = row_rd[KEY_WIDTH + VALUE_WIDTH +: COUNT_WIDTH];

  // Victim order: smallest count first, then the oldest rank.
  assign ev_valid = eval_en && valid[eval_idx];
  assign better   = !victim_found || (rd_count < victim_count) ||
                    ((rd_count == victim_count) && (rank_rd > victim_rank));

  always_ff @(posedge clk) begin
    if (rst) begin
      match_found  <= 1'b0;
      victim_found <= 1'b0;
      free_found   <= 1'b0;
    end else if (cmd.start) begin
      match_found  <= 1'b0;
      victim_found <= 1'b0;
      free_found   <= 1'b0;
    end else if (eval_en) begin
      if (ev_valid && (rd_key == req_key)) begin
        match_found <= 1'b1;
        match_idx   <= eval_idx;
        match_value <= rd_value;
        match_count <= rd_count;
        match_rank  <= rank_rd;
      end
      if (ev_valid && better) begin
        victim_found <= 1'b1;
        victim_idx   <= eval_idx;
        victim_key   <= rd_key;
        victim_count <= rd_count;
        victim_rank  <= rank_rd;
      end
      if (!valid[eval_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= eval_idx;
      end
    end
  end

  assign cap_ext = CAP_W'(cap_cfg);
  assign cap_eff = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
  assign occ_ext = CAP_W'(occ);

  assign touch_c  = match_found && (!req_put || (cap_eff != '0));
  assign insert_c = req_put && !match_found && (cap_eff != '0);
  assign evict_c  = insert_c && (occ_ext >= cap_eff) && victim_found;

  // A new key takes the lowest free entry once the victim is gone.
  always_comb begin
    if (match_found) begin
      target_c = match_idx;
    end else if (evict_c) begin
      target_c = (free_found && (free_idx < victim_idx)) ? free_idx : victim_idx;
    end else begin
      target_c = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_l   <= 1'b0;
      insert_l  <= 1'b0;
      evict_l   <= 1'b0;
      use_thr_l <= 1'b0;
    end else if (cmd.decide) begin
      touch_l   <= touch_c;
      insert_l  <= insert_c;
      evict_l   <= evict_c;
      use_thr_l <= touch_c || evict_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      target_l <= target_c;
      thr_l    <= match_found ? match_rank : victim_rank;
    end
  end

  // Ranks below the threshold age by one; an insert without eviction ages
  // every valid entry. The target entry becomes the most recent.
  always_comb begin
    if (wr_idx == target_l) begin
      rank_new = '0;
    end else if (!use_thr_l || (rank_rd < thr_l)) begin
      rank_new = rank_rd + 1'b1;
    end else begin
      rank_new = rank_rd;
    end
  end

  assign rank_we = wr_en && ((wr_idx == target_l) || valid[wr_idx]);

  assign count_wr = insert_l ? COUNT_WIDTH'(1) :
                    ((match_count == '1) ? match_count : match_count + 1'b1);
  assign value_wr = (touch_l && !req_put) ? match_value : req_value;
  assign row_wr   = {count_wr, value_wr, req_key};

  // The victim leaves first, so a new key that lands on the victim's own
  // entry leaves it valid.
  always_comb begin
    valid_next = valid;
    if (insert_l) begin
      if (evict_l) begin
        valid_next[victim_idx] = 1'b0;
      end
      valid_next[target_l] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (cmd.commit && insert_l) begin
      valid <= valid_next;
      if (!evict_l) begin
        occ <= occ + 1'b1;
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hit         <= match_found;
      read_value  <= (!req_put && match_found) ? match_value : '1;
      evicted     <= evict_l;
      evicted_key <= evict_l ? victim_key : '0;
    end
  end

  assign sts.last        = cnt_last;
  assign sts.need_update = touch_c || insert_c;
  assign sts.out_free    = out_free;

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == occ)
    else $error("occupancy differs from the number of valid entries");

  a_insert_into_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && insert_l) |->
      (!valid[target_l] || (evict_l && (target_l == victim_idx))))
    else $error("insert overwrites a live entry");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && insert_l) |=> valid[target_l])
    else $error("inserted entry not marked valid");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result register overwritten while full");
`endif

endmodule

FILE: tb/sv/lfu_cache_table_test.sv
`timescale 1ns / 100ps

module lfu_cache_table_test;
  import lfu_pkg::*;

  // Self-checking bench for the LFU cache table.
  // A behavioral copy of the table (valid bits, keys, values, use counts and
  // age ranks) runs next to the block. Every request word that the block
  // accepts is applied to that copy, and the answer it gives is queued. Every
  // result word that leaves the block is checked against the oldest queued
  // answer.

  localparam int TABLE_SIZE = DEF_CAPACITY;
  // The use counter is built narrow here so that saturation, and ties among
  // saturated entries, come up many times within a short run.
  localparam int HITS_W = 4;
  localparam int unsigned HITS_MAX = (1 << HITS_W) - 1;
  localparam int WORD_W = ((DEF_KEY_WIDTH + DEF_VALUE_WIDTH + 7) / 8) * 8;
  // A request that changes the table takes two passes over the entries.
  localparam int BUSY_CYCLES = 2 * TABLE_SIZE + 6;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int KEY_POOL = 24;
  localparam int NUM_PHASES = 10;

  // One answer of the cache, as it travels on the result stream.
  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_answer_t;

  // Kinds of rows in the directed script: a request, or a capacity write.
  typedef enum logic [1:0] {STEP_GET, STEP_PUT, STEP_CAP} step_kind_t;

  typedef struct packed {
    step_kind_t    kind;
    logic [31:0]   key;
    logic [31:0]   value;    // new capacity for a capacity row
    logic          typed;    // answer below is given by hand
    cache_answer_t answer;
  } script_row_t;

  localparam cache_answer_t MISS_WORD    = '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0};
  localparam cache_answer_t PUT_HIT_WORD = '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0};
  localparam cache_answer_t BY_MODEL     = '0;

  // Directed opening. Rows without a typed answer take theirs from the
  // behavioral table.
  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // Empty table after reset: lookups of both key extremes miss.
    '{STEP_GET, 32'h0000_0000, 32'h0, 1'b1, MISS_WORD},
    '{STEP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, MISS_WORD},
    // Fill two entries with the value extremes, then read them back.
    '{STEP_PUT, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, MISS_WORD},
    '{STEP_PUT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, MISS_WORD},
    '{STEP_GET, 32'h0000_0000, 32'h0, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{STEP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    // A put on a present key replaces the value and answers with -1.
    '{STEP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, PUT_HIT_WORD},
    '{STEP_GET, 32'h0000_0000, 32'h0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    // Full at two entries: new keys evict the least used entry.
    '{STEP_CAP, 32'h0, 32'd2, 1'b0, BY_MODEL},
    '{STEP_PUT, 32'h0000_0005, 32'h1234_5678, 1'b0, BY_MODEL},
    '{STEP_PUT, 32'h0000_0006, 32'h0000_0000, 1'b0, BY_MODEL},
    '{STEP_GET, 32'h0000_0006, 32'h0, 1'b0, BY_MODEL},
    // Capacity dropped below the occupancy: one eviction per new key.
    '{STEP_CAP, 32'h0, 32'd1, 1'b0, BY_MODEL},
    '{STEP_PUT, 32'h0000_0007, 32'h0000_0007, 1'b0, BY_MODEL},
    '{STEP_PUT, 32'h0000_0008, 32'h0000_0008, 1'b0, BY_MODEL},
    // Capacity zero: puts store nothing, lookups still see old entries.
    '{STEP_CAP, 32'h0, 32'd0, 1'b0, BY_MODEL},
    '{STEP_PUT, 32'h0000_0009, 32'h0000_0009, 1'b1, MISS_WORD},
    '{STEP_PUT, 32'h0000_0008, 32'h0000_0001, 1'b0, BY_MODEL},
    '{STEP_GET, 32'h0000_0008, 32'h0, 1'b0, BY_MODEL},
    '{STEP_GET, 32'h0000_0009, 32'h0, 1'b1, MISS_WORD},
    // Capacity above the table size acts as the table size.
    '{STEP_CAP, 32'h0, 32'd31, 1'b0, BY_MODEL},
    '{STEP_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, BY_MODEL},
    '{STEP_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, BY_MODEL},
    '{STEP_GET, 32'h5555_5555, 32'h0, 1'b0, BY_MODEL}
  };

  // Capacities of the random phases; the extremes and a drop below a full
  // table are among them.
  localparam logic [CFG_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
    5'd16, 5'd3, 5'd1, 5'd0, 5'd2, 5'd17, 5'd8, 5'd31, 5'd5, 5'd16
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [WORD_W-1:0] s_tdata = '0;   // low bits up: lookup_key, write_value
  logic [0:0] s_tuser = REQ_GET;     // req_type
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;        // low bits up: read_value, evicted_key
  logic [1:0] m_tuser;               // low bit up: hit, evicted

  // Behavioral copy of the table.
  logic             shadow_used  [TABLE_SIZE];
  logic [31:0]      shadow_key   [TABLE_SIZE];
  logic [31:0]      shadow_value [TABLE_SIZE];
  int unsigned      shadow_hits  [TABLE_SIZE];
  int unsigned      shadow_age   [TABLE_SIZE];
  int unsigned      shadow_fill = 0;
  logic [CFG_W-1:0] shadow_cap = CAP_RESET;

  cache_answer_t cache_responses [$];
  int mismatches = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;   // while set, neither side idles
  logic [31:0] key_pool [KEY_POOL];

  lfu_cache_table #(
    .COUNT_WIDTH(HITS_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Make entry e the most recent one and raise its use count, which stops
  // at the counter's top value.
  function automatic void promote_entry(int e);
    int i;
    int unsigned r;
    r = shadow_age[e];
    for (i = 0; i < TABLE_SIZE; i++) begin
      if (shadow_used[i] && shadow_age[i] < r) shadow_age[i]++;
    end
    shadow_age[e] = 0;
    if (shadow_hits[e] < HITS_MAX) shadow_hits[e]++;
  endfunction

  // Apply one request to the behavioral table and return the answer the
  // block has to give for it.
  function automatic cache_answer_t serve_request(logic op, logic [31:0] key,
                                                  logic [31:0] value);
    cache_answer_t res;
    int i, found, victim, free_slot;
    int unsigned limit, r;
    res = MISS_WORD;
    found = -1;
    for (i = 0; i < TABLE_SIZE; i++) begin
      if (found < 0 && shadow_used[i] && shadow_key[i] == key) found = i;
    end
    limit = (shadow_cap > TABLE_SIZE) ? TABLE_SIZE : shadow_cap;
    res.hit = (found >= 0);
    if (op == REQ_GET) begin
      if (found >= 0) begin
        res.read_value = shadow_value[found];
        promote_entry(found);
      end
    end else if (limit != 0) begin
      if (found >= 0) begin
        shadow_value[found] = value;
        promote_entry(found);
      end else begin
        // Full (or over the limit after a capacity drop): drop the least
        // used entry, the oldest one among equals.
        if (shadow_fill >= limit) begin
          victim = -1;
          for (i = 0; i < TABLE_SIZE; i++) begin
            if (shadow_used[i] && (victim < 0 || shadow_hits[i] < shadow_hits[victim] ||
                (shadow_hits[i] == shadow_hits[victim] &&
                 shadow_age[i] > shadow_age[victim]))) victim = i;
          end
          if (victim >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = shadow_key[victim];
            shadow_used[victim] = 1'b0;
            r = shadow_age[victim];
            for (i = 0; i < TABLE_SIZE; i++) begin
              if (shadow_used[i] && shadow_age[i] > r) shadow_age[i]--;
            end
            if (shadow_fill > 0) shadow_fill--;
          end
        end
        // The new key takes the lowest free entry and becomes the newest.
        free_slot = -1;
        for (i = 0; i < TABLE_SIZE; i++) begin
          if (free_slot < 0 && !shadow_used[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (i = 0; i < TABLE_SIZE; i++) begin
            if (shadow_used[i]) shadow_age[i]++;
          end
          shadow_used[free_slot] = 1'b1;
          shadow_key[free_slot] = key;
          shadow_value[free_slot] = value;
          shadow_hits[free_slot] = 1;
          shadow_age[free_slot] = 0;
          shadow_fill++;
        end
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
  endtask

  // Offer one request word from a falling edge and hold it until the block
  // takes it. The valid line stays high on return, so a following word can
  // go out back to back; the answer is queued at the accepting edge.
  task automatic offer_request(logic op, logic [31:0] key, logic [31:0] value,
                               logic typed, cache_answer_t typed_answer);
    cache_answer_t res;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {value, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = serve_request(op, key, value);
    cache_responses.push_back(typed ? typed_answer : res);
    @(negedge clk);
  endtask

  task automatic hold_off(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending until every answer is back and the block has had time to
  // finish its table update.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (cache_responses.size() != 0) @(negedge clk);
    repeat (BUSY_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] cap);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    shadow_cap = cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: stalls come in bursts of random length unless quiet.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check every result word against the oldest queued answer.
  always @(posedge clk) begin
    cache_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cache_responses.size() == 0) begin
        flag_mismatch("result word with no request pending", m_tdata[31:0], 32'h0);
      end else begin
        want = cache_responses.pop_front();
        if (m_tuser[0] !== want.hit)
          flag_mismatch("hit", {31'h0, m_tuser[0]}, {31'h0, want.hit});
        if (m_tdata[31:0] !== want.read_value)
          flag_mismatch("read_value", m_tdata[31:0], want.read_value);
        if (m_tuser[1] !== want.evicted)
          flag_mismatch("evicted", {31'h0, m_tuser[1]}, {31'h0, want.evicted});
        if (m_tdata[63:32] !== want.evicted_key)
          flag_mismatch("evicted_key", m_tdata[63:32], want.evicted_key);
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lfu_cache_table verification failed");
      $finish;
    end
  end

  initial begin
    int r, n, phase, pick, hot;
    logic op;
    logic [31:0] key, value;

    for (r = 0; r < TABLE_SIZE; r++) begin
      shadow_used[r] = 1'b0;
      shadow_key[r] = '0;
      shadow_value[r] = '0;
      shadow_hits[r] = 0;
      shadow_age[r] = 0;
    end
    for (r = 0; r < KEY_POOL; r++) key_pool[r] = $urandom;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening, with the table at its reset capacity.
    for (r = 0; r < SCRIPT_LEN; r++) begin
      case (SCRIPT[r].kind)
        STEP_CAP: begin
          set_capacity(SCRIPT[r].value[CFG_W-1:0]);
        end
        STEP_GET: begin
          offer_request(REQ_GET, SCRIPT[r].key, SCRIPT[r].value, SCRIPT[r].typed,
                        SCRIPT[r].answer);
        end
        default: begin
          offer_request(REQ_PUT, SCRIPT[r].key, SCRIPT[r].value, SCRIPT[r].typed,
                        SCRIPT[r].answer);
        end
      endcase
      if (SCRIPT[r].kind != STEP_CAP && $urandom_range(0, 2) == 0) begin
        hold_off($urandom_range(1, 8));
      end
    end

    // Random phases. Most keys come from a small pool: a hot set about the
    // size of the capacity keeps hitting and climbs to saturated counts,
    // and a slightly wider set forces evictions. The rest are fresh random
    // keys and the key extremes.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_capacity(PHASE_CAPS[phase]);
      hot = (shadow_cap > TABLE_SIZE) ? TABLE_SIZE : shadow_cap;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // The last phase runs quiet throughout; earlier ones now and then
        // get a quiet stretch as well.
        if (n % 30 == 0) quiet = (phase == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 45) key = key_pool[$urandom_range(0, hot)];
        else if (pick < 80) key = key_pool[$urandom_range(0, hot + 4 < KEY_POOL ? hot + 4
                                                                    : KEY_POOL - 1)];
        else if (pick < 92) key = $urandom;
        else if (pick < 96) key = 32'h0;
        else key = 32'hFFFF_FFFF;
        op = ($urandom_range(0, 1) == 1) ? REQ_PUT : REQ_GET;
        value = $urandom;
        offer_request(op, key, value, 1'b0, BY_MODEL);
        if ($urandom_range(0, 59) == 0) wait_drained();
        else if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 8));
      end
    end

    s_tvalid <= 1'b0;
    while (cache_responses.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("lfu_cache_table verification clean");
    end else begin
      $display("lfu_cache_table verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lfu_pkg.sv
hdl/lfu_ram.sv
hdl/lfu_ctrl.sv
hdl/lfu_dp.sv
hdl/lfu_cache_table.sv
tb/sv/lfu_cache_table_test.sv
